// ----- rtl/fa2_pkg.sv -----
`timescale 1ns / 1ps

package fa2_pkg;

  // The ratio min/max is unsigned Q0.16 and can reach exactly 1.0, so it needs
  // one bit more than its fraction.
  localparam int RATIO_BITS = 16;
  localparam int RATIO_W    = RATIO_BITS + 1;

  // Width of the Q2.30 numerator and denominator words.
  localparam int P_W = 32;

  // pi with 61 fractional bits. The angle constants are rounded from it.
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  // Octant folding flags that travel alongside each item.
  typedef struct packed {
    logic swap;
    logic x_neg;
    logic y_neg;
  } fa2_quad_t;

endpackage

// ----- rtl/fa2_front.sv -----
`timescale 1ns / 1ps

module fa2_front import fa2_pkg::*; #(
  parameter int IN_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_WIDTH-1:0] y_coord,
  input  logic [IN_WIDTH-1:0] x_coord,
  output logic                out_valid,
  output logic [RATIO_W-1:0]  ratio,
  output fa2_quad_t           out_quad
);

  logic                y_neg;
  logic                x_neg;
  logic [IN_WIDTH-1:0] ay;
  logic [IN_WIDTH-1:0] ax;
  logic [IN_WIDTH-1:0] hi;
  logic [IN_WIDTH-1:0] lo;

  // The most negative input wraps to 2^(IN_WIDTH-1), which is its exact
  // magnitude as an unsigned number.
  assign y_neg = y_coord[IN_WIDTH-1];
  assign x_neg = x_coord[IN_WIDTH-1];
  assign ay    = y_neg ? (~y_coord + 1'b1) : y_coord;
  assign ax    = x_neg ? (~x_coord + 1'b1) : x_coord;
  assign hi    = (ax > ay) ? ax : ay;
  assign lo    = (ax > ay) ? ay : ax;

  // Stage 0 holds the magnitudes; stage k+1 holds the result of quotient step k.
  logic                vld  [0:RATIO_W];
  logic                hz   [0:RATIO_W];
  fa2_quad_t           quad [0:RATIO_W];
  logic [RATIO_W-1:0]  quo  [0:RATIO_W];
  logic [IN_WIDTH:0]   rem  [0:RATIO_W-1];
  logic [IN_WIDTH-1:0] dvs  [0:RATIO_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {1'b0, lo};
      dvs[0]  <= hi;
      quo[0]  <= '0;
      hz[0]   <= (hi == '0);
      quad[0] <= '{swap: (ay > ax), x_neg: x_neg, y_neg: y_neg};
    end
  end

  for (genvar k = 0; k < RATIO_W; k++) begin : g_step
    logic [IN_WIDTH:0] trial;
    logic              ge;

    // The first step tests lo against hi directly, which yields the integer
    // bit of the ratio; every later step brings in one zero bit.
    always_comb begin
      trial = (k == 0) ? rem[k] : {rem[k][IN_WIDTH-1:0], 1'b0};
      ge    = (trial >= {1'b0, dvs[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1]  <= {quo[k][RATIO_W-2:0], ge};
        hz[k+1]   <= hz[k];
        quad[k+1] <= quad[k];
      end
    end

    if (k < RATIO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? (trial - {1'b0, dvs[k]}) : trial;
          dvs[k+1] <= dvs[k];
        end
      end
    end
  end

  // Both inputs zero: the ratio is defined as zero.
  assign out_valid = vld[RATIO_W];
  assign ratio     = hz[RATIO_W] ? '0 : quo[RATIO_W];
  assign out_quad  = quad[RATIO_W];

endmodule

// ----- rtl/fa2_poly.sv -----
`timescale 1ns / 1ps

module fa2_poly import fa2_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [RATIO_W-1:0] ratio,
  input  fa2_quad_t          in_quad,
  output logic               out_valid,
  output logic [P_W-1:0]     num,
  output logic [P_W-1:0]     den,
  output fa2_quad_t          out_quad
);

  localparam int PROD_W = P_W + RATIO_W;

  // Q2.30 coefficients of the rational approximation.
  localparam logic [P_W-1:0] CO_A    = 32'd54011108;
  localparam logic [P_W-1:0] CO_B    = 32'd332840025;
  localparam logic [P_W-1:0] CO_C    = 32'd158312570;
  localparam logic [P_W-1:0] CO_D    = 32'd1073713441;
  localparam logic [P_W-1:0] CO_E    = 32'd338;
  localparam logic [P_W-1:0] CO_F    = 32'd691988024;
  localparam logic [P_W-1:0] CO_G    = 32'd157951624;
  localparam logic [P_W-1:0] ONE_Q30 = 32'd1073741824;

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RATIO_BITS - 1);

  function automatic logic [PROD_W-1:0] qmul(input logic [P_W-1:0] p,
                                             input logic [RATIO_W-1:0] r);
    return PROD_W'(p) * PROD_W'(r);
  endfunction

  // Every intermediate stays below 2^32, so the bits above are dropped.
  function automatic logic [P_W-1:0] qrnd(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] s;
    s = x + RND_HALF;
    return s[RATIO_BITS +: P_W];
  endfunction

  logic [8:1]         vld;
  fa2_quad_t          quad [1:8];
  logic [RATIO_W-1:0] r1, r2, r3, r4, r5, r6;
  logic [PROD_W-1:0]  pa1, fa1, pa3, fa3, pa5, pa7;
  logic [P_W-1:0]     p2, d2, p4, d4, d5, p6, d6, d7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:1], in_valid};
    end
  end

  // Odd stages multiply, even stages round and add.
  always_ff @(posedge clk) begin
    if (en) begin
      quad[1] <= in_quad;
      for (int i = 2; i <= 8; i++) begin
        quad[i] <= quad[i-1];
      end

      r1  <= ratio;
      pa1 <= qmul(CO_A, ratio);
      fa1 <= qmul(CO_F, ratio);

      r2  <= r1;
      p2  <= CO_B - qrnd(pa1);
      d2  <= qrnd(fa1) + CO_G;

      r3  <= r2;
      pa3 <= qmul(p2, r2);
      fa3 <= qmul(d2, r2);

      r4  <= r3;
      p4  <= qrnd(pa3) + CO_C;
      d4  <= qrnd(fa3) + ONE_Q30;

      r5  <= r4;
      pa5 <= qmul(p4, r4);
      d5  <= d4;

      r6  <= r5;
      p6  <= qrnd(pa5) + CO_D;
      d6  <= d5;

      pa7 <= qmul(p6, r6);
      d7  <= d6;

      num <= qrnd(pa7) + CO_E;
      den <= d7;
    end
  end

  assign out_valid = vld[8];
  assign out_quad  = quad[8];

endmodule

// ----- rtl/fa2_div.sv -----
`timescale 1ns / 1ps

module fa2_div import fa2_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [P_W-1:0]             num,
  input  logic [P_W-1:0]             den,
  input  fa2_quad_t                  in_quad,
  output logic                       out_valid,
  output logic [ANGLE_FRAC_BITS-1:0] angle_oct,
  output fa2_quad_t                  out_quad
);

  localparam int F = ANGLE_FRAC_BITS;

  logic [P_W-1:0] half;

  // The dividend is num * 2^F + den/2. Its upper part is num plus the upper
  // bits of den/2, which stays below den; the low F bits are fed in one per step.
  assign half = den >> 1;

  logic           vld  [0:F];
  fa2_quad_t      quad [0:F];
  logic [F-1:0]   quo  [0:F];
  logic [P_W-1:0] rem  [0:F-1];
  logic [P_W-1:0] dvs  [0:F-1];
  logic [F-1:0]   low  [0:F-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num + (half >> F);
      low[0]  <= half[F-1:0];
      dvs[0]  <= den;
      quo[0]  <= '0;
      quad[0] <= in_quad;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_step
    logic [P_W-1:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem[k][P_W-2:0], low[k][F-1]};
      ge    = (trial >= dvs[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1]  <= {quo[k][F-2:0], ge};
        quad[k+1] <= quad[k];
      end
    end

    if (k < F - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? (trial - dvs[k]) : trial;
          dvs[k+1] <= dvs[k];
          low[k+1] <= {low[k][F-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[F];
  assign angle_oct = quo[F];
  assign out_quad  = quad[F];

endmodule

// ----- rtl/fast_atan2_angle_unit.sv -----
// Four-quadrant arctangent: each input transfer carries a signed point
// (y_coord, x_coord) and produces one output transfer with angle = atan2(y, x)
// in radians, signed Q3.ANGLE_FRAC_BITS, between -pi and +pi.
// Both channels use valid/stall; a transfer happens on a rising edge where
// valid is high and stall is low.
// The pipeline runs through the magnitudes, the ratio divider, the rational
// polynomial, the final divider and quadrant folding, in that order. A new
// point is taken every cycle while the output is not stalled; the rate is set
// by the longest stage, a 32 by 17 bit multiply or a 32 bit compare-subtract.
// The pipeline moves as a whole. While a result sits in the output register
// and the receiver stalls, every stage holds and in_stall is raised; as soon
// as the result is taken the next point may enter in the same cycle.
// Synchronous reset clears all valid bits, so no result appears until a point
// has been transferred in.
`timescale 1ns / 1ps

module fast_atan2_angle_unit import fa2_pkg::*; #(
  parameter int IN_WIDTH        = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [IN_WIDTH-1:0]          y_coord,
  input  logic [IN_WIDTH-1:0]          x_coord,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ANGLE_FRAC_BITS+2:0]   angle
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = ANGLE_FRAC_BITS + 3;

  // pi and pi/2 rounded to nearest at F fractional bits.
  localparam logic [63:0] PI_FULL   = (PI_Q61 + (64'd1 << (60 - F))) >> (61 - F);
  localparam logic [63:0] HALF_FULL = (PI_Q61 + (64'd1 << (61 - F))) >> (62 - F);
  localparam logic [AW-1:0] PI_A    = AW'(PI_FULL);
  localparam logic [AW-1:0] HALF_A  = AW'(HALF_FULL);

  // Global advance: everything moves unless a finished result is held back.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic               ratio_valid;
  logic [RATIO_W-1:0] ratio;
  fa2_quad_t          ratio_quad;

  fa2_front #(
    .IN_WIDTH (IN_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .y_coord   (y_coord),
    .x_coord   (x_coord),
    .out_valid (ratio_valid),
    .ratio     (ratio),
    .out_quad  (ratio_quad)
  );

  logic           poly_valid;
  logic [P_W-1:0] num;
  logic [P_W-1:0] den;
  fa2_quad_t      poly_quad;

  fa2_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ratio_valid),
    .ratio     (ratio),
    .in_quad   (ratio_quad),
    .out_valid (poly_valid),
    .num       (num),
    .den       (den),
    .out_quad  (poly_quad)
  );

  logic         oct_valid;
  logic [F-1:0] angle_oct;
  fa2_quad_t    oct_quad;

  fa2_div #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (poly_valid),
    .num       (num),
    .den       (den),
    .in_quad   (poly_quad),
    .out_valid (oct_valid),
    .angle_oct (angle_oct),
    .out_quad  (oct_quad)
  );

  // Fold the first-octant angle out to the full circle. All intermediate
  // values lie within plus or minus pi, so AW bits of two's complement suffice.
  logic [AW-1:0] a0;
  logic [AW-1:0] a1;
  logic [AW-1:0] a2;
  logic [AW-1:0] a3;

  always_comb begin
    a0 = {3'b000, angle_oct};
    a1 = oct_quad.swap  ? (HALF_A - a0) : a0;
    a2 = oct_quad.x_neg ? (PI_A - a1)   : a1;
    a3 = oct_quad.y_neg ? (~a2 + 1'b1)  : a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= oct_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= a3;
    end
  end

endmodule
